// ----- sv/gfpd_pkg.sv -----
// Shared types, codes and GF(2^8) multiply for the polynomial divider.
package gfpd_pkg;

    typedef enum logic [1:0] {
        KIND_QUOT = 2'd0,
        KIND_REM  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_DATA = 1'b1
    } t_cmd;

    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_POLY   = 1'b1;

    localparam logic [5:0] DEGREE_RESET = 6'd16;
    localparam logic [8:0] POLY_RESET   = 9'd285;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       fin;
    } t_result;

    // Broadcast from the controller to every cell of the window chain.
    typedef struct packed {
        logic       step;
        logic       fill;
        logic       clear;
        logic       load_rem;
        logic       shift_rem;
        logic       coef_we;
        logic [5:0] coef_idx;
        logic [7:0] sym;
        logic [7:0] q;
        logic [7:0] red;
    } t_cell_ctl;

    // Shift-and-reduce multiply; red is the low byte of the reduction polynomial.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] red);
        logic [7:0] x;
        logic [7:0] r;
        x = a;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                r = r ^ x;
            end
            if (x[7]) begin
                x = {x[6:0], 1'b0} ^ red;
            end else begin
                x = {x[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/gfpd_cell.sv -----
// One window position: divisor coefficient, pending window entry, remainder tap.
module gfpd_cell
    import gfpd_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  logic [CW-1:0]   i_d_eff,
    input  logic [CW-1:0]   i_seen,
    input  logic [7:0]      i_next_w,
    input  logic [7:0]      i_next_rem,
    output logic [7:0]      o_w,
    output logic [7:0]      o_rem
);

    logic [7:0] r_coef;
    logic [7:0] r_w;
    logic [7:0] r_rem;
    logic [7:0] n_w;
    logic [7:0] prod;
    logic [7:0] shift_in;
    logic       active;
    logic       tail;
    logic       fill_here;
    logic       coef_hit;

    assign active    = CW'(IDX) < i_d_eff;
    assign tail      = CW'(IDX + 1) == i_d_eff;
    assign fill_here = CW'(IDX) == i_seen;
    assign coef_hit  = {26'd0, i_ctl.coef_idx} == 32'(IDX + 1);
    assign prod      = gf_mul(r_coef, i_ctl.q, i_ctl.red);
    assign shift_in  = tail ? i_ctl.sym : i_next_w;

    always_comb begin
        n_w = r_w;
        if (i_ctl.step && active) begin
            n_w = shift_in ^ prod;
        end else if (i_ctl.fill && fill_here) begin
            n_w = i_ctl.sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= 8'h00;
            r_coef <= 8'h00;
        end else begin
            r_w <= i_ctl.clear ? 8'h00 : n_w;
            if (i_ctl.coef_we && coef_hit) begin
                r_coef <= i_ctl.sym;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_rem) begin
            r_rem <= n_w;
        end else if (i_ctl.shift_rem) begin
            r_rem <= i_next_rem;
        end
    end

    assign o_w   = r_w;
    assign o_rem = r_rem;

endmodule

// ----- sv/gfpd_obuf.sv -----
// Two-entry result buffer between the divider and the output stream.
module gfpd_obuf
    import gfpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_a_valid;
    logic    r_b_valid;
    t_result r_a;
    t_result r_b;
    logic    n_a_valid;
    logic    n_b_valid;
    t_result n_a;
    t_result n_b;
    logic    pop;

    assign pop = r_a_valid && i_ready;

    always_comb begin
        n_a_valid = r_a_valid;
        n_b_valid = r_b_valid;
        n_a       = r_a;
        n_b       = r_b;
        if (!r_a_valid || pop) begin
            if (r_b_valid) begin
                n_a_valid = 1'b1;
                n_a       = r_b;
                n_b_valid = i_push;
                n_b       = i_data;
            end else begin
                n_a_valid = i_push;
                n_a       = i_data;
            end
        end else if (i_push) begin
            n_b_valid = 1'b1;
            n_b       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_full  = r_b_valid;
    assign o_valid = r_a_valid;
    assign o_data  = r_a;

endmodule

// ----- sv/gf256_poly_divider_core.sv -----
// Top level of the streamed GF(2^8) polynomial divider.
//
//  channel  dir  transfer when            payload
//  s_*      in   s_tvalid & s_tready      tdata: coef_index, symbol; tuser: command; tlast: last
//  m_*      out  m_tvalid & m_tready      tdata: value; tuser: kind; tlast: final_res
//  apb      in   psel & penable & pwrite  reg 0 divisor_degree, reg 1 field_polynomial
//
//  One symbol or load per cycle while s_tready is high; on a step every active window cell updates in the same cycle.
//  A last symbol that completes a division closes s_tready while the remainder chain
//  shifts out one coefficient per cycle, pausing while the result buffer is full.
//  Reset is synchronous and clears window, divisor and counters at once.
//  A two-entry result buffer sits before m_*; s_tready drops while it is full.
module gf256_poly_divider_core
    import gfpd_pkg::*;
#(
    parameter int MAX_DEGREE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] coef_index, [13:6] symbol, [15:14] zero
    input  logic        s_tuser,   // [0] command
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] value
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_DEGREE + 1);

    logic [5:0]    r_degree;
    logic [8:0]    r_poly;
    logic [CW-1:0] r_seen;
    logic [CW-1:0] n_seen;
    logic [CW-1:0] r_rem_cnt;
    logic [CW-1:0] n_rem_cnt;
    logic [CW-1:0] d_eff;

    logic          acc;
    logic          data_acc;
    logic          ge;
    logic          item_push;
    logic          chain_push;
    logic          buf_push;
    logic          buf_full;
    logic          buf_valid;
    logic          cfg_we;
    logic [5:0]    in_idx;
    logic [7:0]    in_sym;
    t_result       push_data;
    t_result       head;
    t_cell_ctl     ctl;

    logic [7:0]    w_out   [MAX_DEGREE];
    logic [7:0]    rem_out [MAX_DEGREE];

    // configuration
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RESET;
            r_poly   <= POLY_RESET;
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_DEGREE: r_degree <= pwdata[5:0];
                REG_POLY:   r_poly   <= pwdata[8:0];
                default:    r_poly   <= r_poly;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DEGREE: prdata = {26'd0, r_degree};
            REG_POLY:   prdata = {23'd0, r_poly};
            default:    prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_degree == 6'd0) begin
            d_eff = CW'(1);
        end else if (32'(r_degree) > MAX_DEGREE) begin
            d_eff = CW'(MAX_DEGREE);
        end else begin
            d_eff = CW'(r_degree);
        end
    end

    // stream control
    assign in_idx   = s_tdata[5:0];
    assign in_sym   = s_tdata[13:6];
    assign s_tready = !buf_full && (r_rem_cnt == '0);
    assign acc      = s_tvalid && s_tready;
    assign data_acc = acc && (s_tuser == CMD_DATA);
    assign ge       = r_seen >= d_eff;

    always_comb begin
        ctl           = '0;
        ctl.step      = data_acc && ge;
        ctl.fill      = data_acc && !ge;
        ctl.clear     = data_acc && s_tlast;
        ctl.load_rem  = data_acc && s_tlast && ge;
        ctl.shift_rem = chain_push;
        ctl.coef_we   = acc && (s_tuser == CMD_LOAD) && (in_idx != 6'd0)
                        && (32'(in_idx) <= MAX_DEGREE);
        ctl.coef_idx  = in_idx;
        ctl.sym       = in_sym;
        ctl.q         = w_out[0];
        ctl.red       = r_poly[7:0];
    end

    always_comb begin
        n_seen = r_seen;
        if (data_acc && s_tlast) begin
            n_seen = '0;
        end else if (data_acc && (32'(r_seen) < MAX_DEGREE)) begin
            n_seen = r_seen + 1'b1;
        end
    end

    assign item_push  = data_acc && (ge || s_tlast);
    assign chain_push = (r_rem_cnt != '0) && !buf_full;
    assign buf_push   = item_push || chain_push;

    always_comb begin
        n_rem_cnt = r_rem_cnt;
        if (ctl.load_rem) begin
            n_rem_cnt = d_eff;
        end else if (chain_push) begin
            n_rem_cnt = r_rem_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_rem_cnt <= '0;
        end else begin
            r_seen    <= n_seen;
            r_rem_cnt <= n_rem_cnt;
        end
    end

    always_comb begin
        if (chain_push) begin
            push_data.kind  = KIND_REM;
            push_data.value = rem_out[0];
            push_data.fin   = (r_rem_cnt == CW'(1));
        end else if (ge) begin
            push_data.kind  = KIND_QUOT;
            push_data.value = w_out[0];
            push_data.fin   = 1'b0;
        end else begin
            push_data.kind  = KIND_ERR;
            push_data.value = 8'h00;
            push_data.fin   = 1'b1;
        end
    end

    // window chain, entry 0 is the highest order
    for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_cell
        logic [7:0] next_w;
        logic [7:0] next_rem;
        if (k == MAX_DEGREE - 1) begin : g_end
            assign next_w   = 8'h00;
            assign next_rem = 8'h00;
        end else begin : g_mid
            assign next_w   = w_out[k+1];
            assign next_rem = rem_out[k+1];
        end
        gfpd_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_d_eff    (d_eff),
            .i_seen     (r_seen),
            .i_next_w   (next_w),
            .i_next_rem (next_rem),
            .o_w        (w_out[k]),
            .o_rem      (rem_out[k])
        );
    end

    gfpd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (buf_push),
        .i_data  (push_data),
        .o_full  (buf_full),
        .o_valid (buf_valid),
        .i_ready (m_tready),
        .o_data  (head)
    );

    assign m_tvalid = buf_valid;
    assign m_tdata  = head.value;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.fin;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_push |-> !buf_full)
        else $error("result pushed into a full buffer");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_seen) <= MAX_DEGREE)
        else $error("symbol count beyond maximum degree");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        data_acc && s_tlast |=> r_seen == '0)
        else $error("symbol count not cleared after last symbol");

    a_rem_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_push && (r_rem_cnt == CW'(1)) |=> r_rem_cnt == '0)
        else $error("remainder drain did not end on final coefficient");

endmodule

// ----- sim/tb_gf256_poly_divider_core.sv -----
// Self-checking testbench for the streamed GF(2^8) polynomial divider core.
`timescale 1ns / 1ps

module tb_gf256_poly_divider_core;
    import gfpd_pkg::*;

    localparam int MAXD        = 32;
    localparam int DRAIN       = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        t_cmd       cmd;
        logic [5:0] idx;
        logic [7:0] sym;
        logic       last;
    } t_div_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [5:0] coef_index, [13:6] symbol, [15:14] zero
    logic        s_tuser;   // [0] command
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] value
    logic [1:0]  m_tuser;   // [1:0] kind
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gf256_poly_divider_core #(.MAX_DEGREE(MAXD)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // divider state mirror
    logic [7:0] div_coef [MAXD];
    logic [7:0] div_window [MAXD];
    int         div_seen;
    logic [5:0] cfg_degree;
    logic [8:0] cfg_poly;

    t_div_item pending_symbols [$];
    t_result   expected_coefs [$];
    t_div_item nxt;
    t_result   want;
    int        items_queued;
    int        items_taken;
    int        errs;
    logic      in_fire;
    bit        calm;
    bit        hold_go;
    int        hold_cnt;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] red);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? red : 8'h00);
            if (b[i]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    function automatic int active_degree();
        if (cfg_degree == 6'd0) begin
            return 1;
        end else if (cfg_degree > MAXD) begin
            return MAXD;
        end
        return int'(cfg_degree);
    endfunction

    task automatic push_coef(input t_kind kind, input logic [7:0] value, input logic fin);
        t_result r;
        r.kind  = kind;
        r.value = value;
        r.fin   = fin;
        expected_coefs.push_back(r);
    endtask

    task automatic predict_division(input t_cmd cmd, input logic [5:0] idx,
                                    input logic [7:0] sym, input logic last);
        int d;
        logic [7:0] q;
        d = active_degree();
        if (cmd == CMD_LOAD) begin
            if (idx >= 1 && idx <= MAXD) begin
                div_coef[idx - 1] = sym;
            end
        end else begin
            if (div_seen >= d) begin
                q = div_window[0];
                push_coef(KIND_QUOT, q, 1'b0);
                for (int k = 0; k + 1 < d; k++) begin
                    div_window[k] = div_window[k + 1] ^ gf_product(div_coef[k], q, cfg_poly[7:0]);
                end
                div_window[d - 1] = sym ^ gf_product(div_coef[d - 1], q, cfg_poly[7:0]);
            end else begin
                div_window[div_seen] = sym;
            end
            if (last) begin
                if (div_seen >= d) begin
                    for (int k = 0; k < d; k++) begin
                        push_coef(KIND_REM, div_window[k], k == d - 1);
                    end
                end else begin
                    push_coef(KIND_ERR, 8'h00, 1'b1);
                end
                for (int k = 0; k < MAXD; k++) begin
                    div_window[k] = 8'h00;
                end
                div_seen = 0;
            end else if (div_seen < MAXD) begin
                div_seen++;
            end
        end
    endtask

    // input side: a transfer is consumed when the previous offer was taken
    always @(negedge i_clk) begin
        if (!s_tvalid || in_fire) begin
            if (i_rst_n && pending_symbols.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
                nxt = pending_symbols.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, nxt.sym, nxt.idx};
                s_tuser  <= nxt.cmd;
                s_tlast  <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output side, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_go && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 12);
        end
    end

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_coefs.size() == 0) begin
                    $error("unexpected transfer: kind %0d value %02h last %0b",
                           m_tuser, m_tdata, m_tlast);
                    errs++;
                end else begin
                    want = expected_coefs.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
                        errs++;
                    end
                    if (m_tdata !== want.value) begin
                        $error("value: expected %02h, actual %02h", want.value, m_tdata);
                        errs++;
                    end
                    if (m_tlast !== want.fin) begin
                        $error("final_res: expected %0b, actual %0b", want.fin, m_tlast);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_division(t_cmd'(s_tuser), s_tdata[5:0], s_tdata[13:6], s_tlast);
                items_taken++;
            end
        end
    end

    task automatic queue_item(input t_cmd cmd, input logic [5:0] idx, input logic [7:0] sym,
                              input logic last);
        t_div_item it;
        it.cmd  = cmd;
        it.idx  = idx;
        it.sym  = sym;
        it.last = last;
        pending_symbols.push_back(it);
        items_queued++;
    endtask

    task automatic queue_dividend(input int len, input bit close);
        for (int i = 0; i < len; i++) begin
            queue_item(CMD_DATA, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                       close && (i == len - 1));
        end
    endtask

    // mostly whole divisions, some short ones, reloads and stray loads
    task automatic queue_phase(input int budget);
        int made;
        int d;
        int r;
        int n;
        made = 0;
        d = active_degree();
        while (made < budget) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    queue_item(CMD_LOAD, 6'($urandom_range(1, MAXD)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
                end
                made += n;
            end else if (r < 20) begin
                queue_item(CMD_LOAD, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
            end else begin
                if (r < 30) begin
                    n = $urandom_range(1, d);
                end else if (r < 36) begin
                    n = d + $urandom_range(1, 40);
                end else begin
                    n = d + 1 + $urandom_range(0, 6);
                end
                queue_dividend(n, 1'b1);
                made += n;
            end
        end
        // leave a dividend open so the next setting applies mid-stream
        if ($urandom_range(0, 2) == 0) begin
            queue_dividend($urandom_range(1, d + 2), 1'b0);
        end
    endtask

    task automatic settle();
        while (pending_symbols.size() != 0 || items_taken != items_queued ||
               expected_coefs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic sel, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (sel == REG_DEGREE) begin
            cfg_degree = data[5:0];
        end else begin
            cfg_poly = data[8:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int deg_plan [12];
        int poly_plan [12];
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_fire  = 1'b0;
        calm     = 1'b0;
        hold_go  = 1'b0;
        hold_cnt = 0;
        items_queued = 0;
        items_taken  = 0;
        errs         = 0;
        div_seen     = 0;
        cfg_degree   = DEGREE_RESET;
        cfg_poly     = POLY_RESET;
        for (int k = 0; k < MAXD; k++) begin
            div_coef[k]   = 8'h00;
            div_window[k] = 8'h00;
        end
        deg_plan  = '{1, 32, 0, 63, 4, 2, 8, 33, 16, 3, 1, 1};
        poly_plan = '{256, 511, -1, 0, 391, -1, 285, -1, 77, -1, -1, 511};
        deg_plan[10]  = $urandom_range(1, 12);
        deg_plan[11]  = $urandom_range(0, 63);
        poly_plan[9]  = $urandom_range(256, 511);
        poly_plan[10] = $urandom_range(0, 511);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray loads, extreme coefficients, short dividends at the reset setting
        queue_item(CMD_LOAD, 6'd0,  8'hFF, 1'b0);
        queue_item(CMD_LOAD, 6'd33, 8'hFF, 1'b0);
        queue_item(CMD_LOAD, 6'd63, 8'hAA, 1'b1);
        queue_item(CMD_LOAD, 6'd1,  8'hFF, 1'b0);
        queue_item(CMD_LOAD, 6'd32, 8'h80, 1'b0);
        queue_item(CMD_LOAD, 6'd16, 8'h01, 1'b1);
        queue_item(CMD_DATA, 6'd0,  8'h00, 1'b1);
        queue_item(CMD_DATA, 6'd63, 8'hFF, 1'b0);
        queue_item(CMD_DATA, 6'd21, 8'h00, 1'b1);
        settle();
        apb_write(REG_DEGREE, 32'd2);
        apb_write(REG_POLY, 32'd511);
        @(posedge i_clk);
        queue_item(CMD_LOAD, 6'd2,  8'h55, 1'b0);
        queue_item(CMD_DATA, 6'd42, 8'hFF, 1'b0);
        queue_item(CMD_DATA, 6'd0,  8'h00, 1'b0);
        queue_item(CMD_DATA, 6'd63, 8'hFF, 1'b0);
        queue_item(CMD_DATA, 6'd5,  8'h80, 1'b0);
        queue_item(CMD_DATA, 6'd0,  8'h01, 1'b1);
        queue_item(CMD_DATA, 6'd0,  8'hA5, 1'b0);
        queue_item(CMD_DATA, 6'd0,  8'h5A, 1'b0);
        queue_item(CMD_DATA, 6'd0,  8'hFF, 1'b0);
        settle();
        // degree zero behaves as one, applied to the open dividend
        apb_write(REG_DEGREE, 32'd0);
        @(posedge i_clk);
        queue_item(CMD_DATA, 6'd0, 8'h3C, 1'b0);
        queue_item(CMD_DATA, 6'd0, 8'hC3, 1'b1);

        for (int ph = 0; ph < 12; ph++) begin
            settle();
            apb_write(REG_DEGREE, 32'(deg_plan[ph]));
            if (poly_plan[ph] >= 0) begin
                apb_write(REG_POLY, 32'(poly_plan[ph]));
            end
            @(posedge i_clk);
            calm <= (ph == 6);
            if (ph == 4) begin
                hold_go <= 1'b1;
            end
            queue_phase(25);
        end

        while (pending_symbols.size() != 0 || items_taken != items_queued ||
               expected_coefs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN) @(negedge i_clk);
        if (errs == 0 && expected_coefs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/gfpd_pkg.sv
sv/gfpd_cell.sv
sv/gfpd_obuf.sv
sv/gf256_poly_divider_core.sv
sim/tb_gf256_poly_divider_core.sv
